@@ design/string_escape_encoder_defines.svh @@
// Shared assertion macros for the string escape encoder checkers.
`ifndef STRING_ESCAPE_ENCODER_DEFINES_SVH
`define STRING_ESCAPE_ENCODER_DEFINES_SVH

// Check on every clock edge outside of reset
`define SEE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check on every clock edge, reset included
`define SEE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ design/see_pkg.sv @@
`default_nettype none

package see_pkg;

    // Longest run one request can cause: open quote, six escape bytes, close quote
    localparam int unsigned MAX_RUN    = 8;
    localparam int unsigned ENC_MAX    = 6;
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef logic [7:0] ch_t;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_PCT  = 2'd1,
        MODE_JSON = 2'd2,
        MODE_CSV  = 2'd3
    } mode_t;

    localparam ch_t CH_QUOTE   = 8'h22;
    localparam ch_t CH_PCT     = 8'h25;
    localparam ch_t CH_SLASH   = 8'h2f;
    localparam ch_t CH_BSLASH  = 8'h5c;
    localparam ch_t CH_ZERO    = 8'h30;
    localparam ch_t CH_LOWER_A = 8'h61;
    localparam ch_t CH_U       = 8'h75;
    localparam ch_t CH_CTRL_HI = 8'h20;
    localparam ch_t HIGH_PRINT = 8'd126;

    // Escape bytes for one source byte
    typedef struct packed {
        logic [ENC_MAX-1:0][7:0] bytes;
        logic [2:0]              count;
    } enc_t;

    // One queued run of result bytes
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [2:0]              last_idx;
        logic                    closes;
    } run_t;

    function automatic ch_t hex_char(input logic [3:0] nib);
        ch_t r;
        if (nib < 4'd10) begin
            r = CH_ZERO + {4'd0, nib};
        end else begin
            r = CH_LOWER_A + {4'd0, nib} - 8'd10;
        end
        return r;
    endfunction

    function automatic enc_t encode_byte(input mode_t mode, input ch_t c);
        enc_t r;
        ch_t  letter;
        r          = '0;
        r.bytes[0] = c;
        r.count    = 3'd1;
        letter     = '0;
        unique case (mode)
            MODE_RAW: begin
                r.count = 3'd1;
            end
            MODE_PCT: begin
                if (c < CH_CTRL_HI || c == CH_PCT || c == CH_QUOTE || c > HIGH_PRINT) begin
                    r.bytes[0] = CH_PCT;
                    r.bytes[1] = hex_char(c[7:4]);
                    r.bytes[2] = hex_char(c[3:0]);
                    r.count    = 3'd3;
                end
            end
            MODE_CSV: begin
                if (c == CH_QUOTE) begin
                    r.bytes[1] = c;
                    r.count    = 3'd2;
                end
            end
            MODE_JSON: begin
                unique case (c)
                    8'h08:     letter = 8'h62;
                    8'h0a:     letter = 8'h6e;
                    8'h0d:     letter = 8'h72;
                    8'h09:     letter = 8'h74;
                    8'h0c:     letter = 8'h66;
                    CH_QUOTE:  letter = CH_QUOTE;
                    CH_BSLASH: letter = CH_BSLASH;
                    CH_SLASH:  letter = CH_SLASH;
                    default:   letter = '0;
                endcase
                if (letter != '0) begin
                    r.bytes[0] = CH_BSLASH;
                    r.bytes[1] = letter;
                    r.count    = 3'd2;
                end else if (c < CH_CTRL_HI) begin
                    r.bytes[0] = CH_BSLASH;
                    r.bytes[1] = CH_U;
                    r.bytes[2] = CH_ZERO;
                    r.bytes[3] = CH_ZERO;
                    r.bytes[4] = hex_char(c[7:4]);
                    r.bytes[5] = hex_char(c[3:0]);
                    r.count    = 3'd6;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/see_front.sv @@
`default_nettype none

module see_front import see_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data,
    input  wire logic       queue_full,
    output logic            push,
    output run_t            push_run
);

    mode_t  mode_reg, mode_next;
    logic   inside_reg, inside_next;
    logic   accept;
    logic   active;
    enc_t   enc;
    logic [MAX_RUN-2:0][7:0] body;
    logic [2:0] body_len;
    logic       body_closes;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign active   = s_tuser || inside_reg;
    assign push     = accept && active;
    assign enc      = encode_byte(mode_reg, s_tdata);

    // Build the escaped body, with the closing quote where it applies
    always_comb begin
        body        = '0;
        body_len    = 3'd1;
        body_closes = 1'b0;
        if (s_tdata == '0) begin
            body[0]     = CH_QUOTE;
            body_closes = 1'b1;
        end else begin
            for (int j = 0; j < int'(ENC_MAX); j++) begin
                body[j] = enc.bytes[j];
            end
            for (int j = 0; j < int'(MAX_RUN) - 1; j++) begin
                if (s_tlast && 3'(j) == enc.count) begin
                    body[j] = CH_QUOTE;
                end
            end
            body_len    = enc.count + {2'd0, s_tlast};
            body_closes = s_tlast;
        end
    end

    // Prepend the opening quote on a start mark
    always_comb begin
        push_run        = '0;
        push_run.closes = body_closes;
        if (s_tuser) begin
            push_run.bytes[0] = CH_QUOTE;
            for (int i = 1; i < int'(MAX_RUN); i++) begin
                push_run.bytes[i] = body[i-1];
            end
            push_run.last_idx = body_len;
        end else begin
            for (int i = 0; i < int'(MAX_RUN) - 1; i++) begin
                push_run.bytes[i] = body[i];
            end
            push_run.last_idx = body_len - 3'd1;
        end
    end

    // Track the open string and the mode register
    always_comb begin
        inside_next = inside_reg;
        mode_next   = mode_reg;
        if (push) begin
            inside_next = !(s_tdata == '0 || s_tlast);
        end
        if (cfg_wr_en) begin
            mode_next = mode_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_reg <= 1'b0;
            mode_reg   <= MODE_JSON;
        end else begin
            inside_reg <= inside_next;
            mode_reg   <= mode_next;
        end
    end

endmodule

`default_nettype wire

@@ design/see_fifo.sv @@
`default_nettype none

module see_fifo import see_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic wr_en,
    input  run_t      wr_run,
    output logic      full,
    input  wire logic rd_en,
    output run_t      rd_run,
    output logic      not_empty
);

    run_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign full      = count_reg == CNT_W'(FIFO_DEPTH);
    assign not_empty = count_reg != '0;
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_run    = mem[rd_ptr_reg];

    // Advance pointers with wrap and keep the fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the run
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_run;
        end
    end

endmodule

`default_nettype wire

@@ design/see_back.sv @@
`default_nettype none

module see_back import see_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  run_t            head_run,
    input  wire logic       head_valid,
    output logic            pop,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    ch_t        data_reg, data_next;
    logic       last_reg, last_next;
    logic       close_reg, close_next;
    logic       load;
    logic       at_last;

    assign load    = head_valid && (!valid_reg || m_tready);
    assign at_last = idx_reg == head_run.last_idx;
    assign pop     = load && at_last;

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;
    assign m_tuser  = close_reg;

    // Step through the head run one byte per request, drop the output once taken
    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        close_next = close_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = head_run.bytes[idx_reg];
            last_next  = at_last;
            close_next = at_last && head_run.closes;
            idx_next   = at_last ? '0 : idx_reg + 3'd1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        last_reg  <= last_next;
        close_reg <= close_next;
    end

endmodule

`default_nettype wire

@@ design/string_escape_encoder.sv @@
// The taken input request is written into the run queue, then the output register loads
// its first result byte. Throughput: one result byte per cycle while m_tready is high
// and the queue holds a run; an item expands to 1 to 8 bytes at the single-byte output.
// Input requests are taken every cycle while the two-entry run queue has room.
// Reset (aresetn low, synchronous): no string open, queue empty, mode set to JSON.
`default_nettype none

module string_escape_encoder import see_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tuser,   // [0] starts_string
    input  wire logic       s_tlast,   // ends_string
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tuser,   // [0] closes_string
    output logic            m_tlast,   // last_of_run
    input  wire logic       cfg_wr_en,
    input  wire logic [1:0] cfg_wr_data
);

    logic queue_full;
    logic push;
    run_t push_run;
    logic pop;
    run_t head_run;
    logic head_valid;

    see_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .queue_full  (queue_full),
        .push        (push),
        .push_run    (push_run)
    );

    see_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .wr_en     (push),
        .wr_run    (push_run),
        .full      (queue_full),
        .rd_en     (pop),
        .rd_run    (head_run),
        .not_empty (head_valid)
    );

    see_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_run   (head_run),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

@@ design/see_checker.sv @@
`default_nettype none
`include "string_escape_encoder_defines.svh"

module see_checker import see_pkg::*; (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // A stalled result keeps every field until it is taken
    property p_out_hold;
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser);
    endproperty

    // Hold a stalled result
    `SEE_ASSERT(a_out_hold, p_out_hold, "stalled result changed")

    // A closing quote always ends its run
    `SEE_ASSERT(a_close_is_last, m_tvalid && m_tuser |-> m_tlast, "closing quote not last of run")

    // A closing byte is the quote character
    `SEE_ASSERT(a_close_is_quote, m_tvalid && m_tuser |-> m_tdata == CH_QUOTE, "closing byte not a quote")

    // Drop the output after reset
    `SEE_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule

bind string_escape_encoder see_checker u_see_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
